FILE: hdl/qbu_pkg.sv
`timescale 1ns / 1ps

package qbu_pkg;

  // Phase codes of the block parser.
  localparam logic [1:0] PH_COUNT  = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BASEHI = 2'd2;
  localparam logic [1:0] PH_DATA   = 2'd3;

  localparam int unsigned ACC_W = 15;  // up to 7 carried bits plus one fresh byte
  localparam int unsigned CNT_W = 4;   // results per word, 1 to 8

  // A burst of results caused by one input word.
  typedef struct packed {
    logic [5:0]       base;
    logic [ACC_W-1:0] acc;
    logic [2:0]       width;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       rep;
    logic             rend;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

endpackage

FILE: hdl/qbu_decode.sv
`timescale 1ns / 1ps

module qbu_decode import qbu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic [7:0] in_byte_i,
  output job_req_t   req_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] values_left_q, values_left_d;
  logic [2:0] value_width_q, value_width_d;
  logic [5:0] base_value_q, base_value_d;
  logic [6:0] carry_bits_q, carry_bits_d;
  logic [2:0] carry_count_q, carry_count_d;

  logic [5:0]       base_hi;
  logic [5:0]       unp_base;
  logic [7:0]       fresh;
  logic [6:0]       carry_in;
  logic [2:0]       cc_in;
  logic [3:0]       nbits;
  logic [ACC_W-1:0] acc;
  logic [3:0]       total;
  logic [CNT_W-1:0] n;
  logic [5:0]       nw;
  logic [7:0]       left;

  always_comb begin
    base_hi = {in_byte_i[0], base_value_q[4:0]};
    if (phase_q == PH_BASEHI) begin
      fresh    = {1'b0, in_byte_i[7:1]};
      carry_in = '0;
      cc_in    = '0;
      nbits    = 4'd7;
      unp_base = base_hi;
    end else begin
      fresh    = in_byte_i;
      carry_in = carry_bits_q;
      cc_in    = carry_count_q;
      nbits    = 4'd8;
      unp_base = base_value_q;
    end
    acc   = ACC_W'(carry_in) | (ACC_W'(fresh) << cc_in);
    total = {1'b0, cc_in} + nbits;
    // Number of complete values in this word, at most eight.
    n = '0;
    for (int k = 1; k <= 8; k++) begin
      if (value_width_q != 3'd0 && 6'(k) * 6'(value_width_q) <= 6'(total)
          && 8'(k) <= values_left_q) begin
        n = CNT_W'(k);
      end
    end
    nw   = 6'(n) * 6'(value_width_q);
    left = values_left_q - 8'(n);
  end

  always_comb begin
    phase_d       = phase_q;
    values_left_d = values_left_q;
    value_width_d = value_width_q;
    base_value_d  = base_value_q;
    carry_bits_d  = carry_bits_q;
    carry_count_d = carry_count_q;
    req_o         = '0;
    case (phase_q)
      PH_COUNT: begin
        if (in_byte_i == 8'd0) begin
          // Record terminator: one result with zero repeat.
          req_o.valid    = 1'b1;
          req_o.job.cnt  = CNT_W'(1);
          req_o.job.rend = 1'b1;
        end else begin
          values_left_d = in_byte_i;
          phase_d       = PH_HEADER;
        end
      end
      PH_HEADER: begin
        value_width_d = in_byte_i[2:0];
        base_value_d  = {1'b0, in_byte_i[7:3]};
        phase_d       = PH_BASEHI;
      end
      default: begin
        if (phase_q == PH_BASEHI) begin
          base_value_d = base_hi;
        end
        if (phase_q == PH_BASEHI && value_width_q == 3'd0) begin
          // Zero width means the whole block is one run of the base.
          req_o.valid    = 1'b1;
          req_o.job.base = base_hi;
          req_o.job.cnt  = CNT_W'(1);
          req_o.job.rep  = values_left_q;
          values_left_d  = '0;
          carry_bits_d   = '0;
          carry_count_d  = '0;
          phase_d        = PH_COUNT;
        end else begin
          values_left_d = left;
          if (left == 8'd0) begin
            phase_d       = PH_COUNT;
            carry_bits_d  = '0;
            carry_count_d = '0;
          end else begin
            phase_d       = PH_DATA;
            carry_bits_d  = 7'(acc >> nw[3:0]);
            carry_count_d = 3'(total - nw[3:0]);
          end
          if (n != '0) begin
            req_o.valid     = 1'b1;
            req_o.job.base  = unp_base;
            req_o.job.acc   = acc;
            req_o.job.width = value_width_q;
            req_o.job.cnt   = n;
            req_o.job.rep   = 8'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_COUNT;
      values_left_q <= '0;
      value_width_q <= '0;
      base_value_q  <= '0;
      carry_bits_q  <= '0;
      carry_count_q <= '0;
    end else if (in_fire_i) begin
      phase_q       <= phase_d;
      values_left_q <= values_left_d;
      value_width_q <= value_width_d;
      base_value_q  <= base_value_d;
      carry_bits_q  <= carry_bits_d;
      carry_count_q <= carry_count_d;
    end
  end

endmodule

FILE: hdl/qbu_emit.sv
`timescale 1ns / 1ps

module qbu_emit import qbu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  job_t       job_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] quality_o,
  output logic [7:0] repeat_count_o,
  output logic       record_end_o,
  output logic       last_o
);

  logic valid_q;
  job_t job_q;
  logic take;
  logic [6:0] mask;

  assign take = valid_q && out_ready_i;
  assign mask = 7'((8'd1 << job_q.width) - 8'd1);

  assign out_valid_o    = valid_q;
  assign quality_o      = 8'(job_q.base) + 8'(job_q.acc[6:0] & mask);
  assign repeat_count_o = job_q.rep;
  assign record_end_o   = job_q.rend;
  assign last_o         = (job_q.cnt == CNT_W'(1));
  // A new burst may load while the final word of the current one leaves.
  assign free_o         = !valid_q || (take && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take && last_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      job_q <= job_i;
    end else if (take) begin
      job_q.acc <= job_q.acc >> job_q.width;
      job_q.cnt <= job_q.cnt - CNT_W'(1);
    end
  end

endmodule

FILE: hdl/quality_block_unpacker.sv
`timescale 1ns / 1ps

// Channel   Signals                                          Direction
// input     in_valid_i, in_ready_o, in_byte_i                in
// result    out_valid_o, out_ready_i, quality_o,             out
//           repeat_count_o, record_end_o, last_o
//
// A byte is parsed in the cycle it is accepted; its results then leave one per cycle from the
// burst register while out_ready_i is high, and the next byte waits until the last of them leaves.
// A byte that causes no result is taken once the burst register has drained.
// Reset clears the parser to expect a count byte and empties the burst register.
// in_ready_o is high while the burst register is empty or its final word is being taken.

module quality_block_unpacker import qbu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] quality_o,
  output logic [7:0] repeat_count_o,
  output logic       record_end_o,
  output logic       last_o
);

  logic     in_fire;
  job_req_t req;

  assign in_fire = in_valid_i && in_ready_o;

  qbu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .in_byte_i (in_byte_i),
    .req_o     (req)
  );

  qbu_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_fire && req.valid),
    .job_i          (req.job),
    .free_o         (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .quality_o      (quality_o),
    .repeat_count_o (repeat_count_o),
    .record_end_o   (record_end_o),
    .last_o         (last_o)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qbu_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS = 470;

  typedef struct {
    logic [7:0] quality;
    logic [7:0] repeat_count;
    logic       record_end;
    logic       last;
  } score_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] in_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] quality_o;
  logic [7:0] repeat_count_o;
  logic       record_end_o;
  logic       last_o;

  // Shadow of the parser state.
  logic [1:0] blk_phase;
  logic [7:0] offsets_left;
  logic [2:0] offset_width;
  logic [5:0] block_base;
  logic [6:0] spare_bits;
  logic [2:0] spare_count;

  score_t pending_scores[$];
  int     errors;
  int     words_sent;
  int     scores_checked;
  int     blocks_seen;
  int     records_ended;
  int     quiet_cycles;
  logic   gaps_on;
  logic   stalls_on;

  quality_block_unpacker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .quality_o      (quality_o),
    .repeat_count_o (repeat_count_o),
    .record_end_o   (record_end_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Merge fresh bits with the spare bits and emit every complete offset.
  task automatic unpack_offsets(input logic [7:0] fresh, input int nbits);
    logic [14:0] acc;
    logic [7:0]  mask;
    int          total;
    int          n;
    score_t      burst[8];
    acc = 15'(spare_bits) | (15'(fresh) << spare_count);
    total = int'(spare_count) + nbits;
    mask = (8'd1 << offset_width) - 8'd1;
    n = 0;
    while (offset_width != 3'd0 && total >= int'(offset_width) && offsets_left != 8'd0
           && n < 8) begin
      burst[n].quality = {2'b00, block_base} + (acc[7:0] & mask);
      burst[n].repeat_count = 8'd1;
      burst[n].record_end = 1'b0;
      burst[n].last = 1'b0;
      n++;
      acc = acc >> offset_width;
      total -= int'(offset_width);
      offsets_left = offsets_left - 8'd1;
    end
    if (offsets_left == 8'd0) begin
      blk_phase = PH_COUNT;
      spare_bits = '0;
      spare_count = '0;
    end else begin
      blk_phase = PH_DATA;
      spare_bits = acc[6:0];
      spare_count = total[2:0];
    end
    if (n > 0) burst[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_scores.insert(pending_scores.size(), burst[i]);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    score_t s;
    case (blk_phase)
      PH_COUNT: begin
        if (b == 8'd0) begin
          s.quality = 8'd0;
          s.repeat_count = 8'd0;
          s.record_end = 1'b1;
          s.last = 1'b1;
          pending_scores.insert(pending_scores.size(), s);
          records_ended++;
        end else begin
          offsets_left = b;
          blk_phase = PH_HEADER;
          blocks_seen++;
        end
      end
      PH_HEADER: begin
        offset_width = b[2:0];
        block_base = {1'b0, b[7:3]};
        blk_phase = PH_BASEHI;
      end
      PH_BASEHI: begin
        block_base[5] = b[0];
        spare_bits = '0;
        spare_count = '0;
        if (offset_width == 3'd0) begin
          // A width of zero is a run: the base repeated count times.
          s.quality = {2'b00, block_base};
          s.repeat_count = offsets_left;
          s.record_end = 1'b0;
          s.last = 1'b1;
          pending_scores.insert(pending_scores.size(), s);
          offsets_left = 8'd0;
          blk_phase = PH_COUNT;
        end else begin
          unpack_offsets({1'b0, b[7:1]}, 7);
        end
      end
      default: unpack_offsets(b, 8);
    endcase
  endtask

  task automatic report_field(input string field, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic check_score();
    score_t want;
    if (pending_scores.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual quality %0d repeat %0d",
               $time, quality_o, repeat_count_o);
    end else begin
      want = pending_scores.pop_front();
      scores_checked++;
      if (quality_o !== want.quality) report_field("quality", want.quality, quality_o);
      if (repeat_count_o !== want.repeat_count)
        report_field("repeat_count", want.repeat_count, repeat_count_o);
      if (record_end_o !== want.record_end)
        report_field("record_end", want.record_end, record_end_o);
      if (last_o !== want.last) report_field("last", want.last, last_o);
    end
  endtask

  // Prediction comes first so that a result can never overtake its word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) decode_byte(in_byte_i);
      if (out_valid_o && out_ready_i) check_score();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("FAIL quality_block_unpacker");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: a random stall before each word, with calm stretches in between.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    stalls_on = 1'b1;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) stalls_on = ~stalls_on;
      stall = stalls_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gaps_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  task automatic test_record_end();
    send_byte(8'h00);
  endtask

  // Largest run with the highest base, then the smallest run at base zero.
  task automatic test_run_blocks();
    send_byte(8'hff);
    send_byte(8'hf8);
    send_byte(8'h01);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hfe);
  endtask

  // One-bit offsets: seven from the third word, then a full burst of eight.
  task automatic test_narrow_offsets();
    send_byte(8'd15);
    send_byte(8'h09);
    send_byte(8'hab);
    send_byte(8'h5c);
  endtask

  // Seven-bit offsets at the top of the range; the last word pads out one bit.
  task automatic test_wide_offsets();
    send_byte(8'd2);
    send_byte(8'hff);
    send_byte(8'hff);
    send_byte(8'hff);
  endtask

  // Three-bit offsets leave one bit over that joins the next word.
  task automatic test_carry_across_bytes();
    send_byte(8'd5);
    send_byte(8'h53);
    send_byte(8'h6d);
    send_byte(8'hb4);
    send_byte(8'h00);
  endtask

  task automatic test_random_records(input int target);
    int start;
    int pick;
    int cnt;
    int width;
    int data_words;
    start = words_sent;
    while (words_sent - start < target) begin
      if ($urandom_range(0, 39) == 0) gaps_on = ~gaps_on;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        send_byte(8'h00);
      end else if (pick == 2) begin
        // A block cut short after its header.
        send_byte(8'($urandom_range(1, 255)));
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        cnt = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
        width = $urandom_range(0, 7);
        send_byte(8'(cnt));
        send_byte({5'($urandom_range(0, 31)), 3'(width)});
        send_byte(8'($urandom_range(0, 255)));
        data_words = (cnt * width) / 8;
        repeat (data_words) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 2) == 0) send_byte(8'h00);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = 8'h00;
    errors = 0;
    words_sent = 0;
    scores_checked = 0;
    blocks_seen = 0;
    records_ended = 0;
    gaps_on = 1'b1;
    blk_phase = PH_COUNT;
    offsets_left = '0;
    offset_width = '0;
    block_base = '0;
    spare_bits = '0;
    spare_count = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_record_end();
    test_run_blocks();
    test_narrow_offsets();
    test_wide_offsets();
    test_carry_across_bytes();
    test_random_records(RANDOM_WORDS);
    in_valid_i <= 1'b0;

    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_scores.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected but never seen", $time, pending_scores.size());
    end

    $display("Sent %0d stream bytes holding %0d blocks and %0d record terminators.",
             words_sent, blocks_seen, records_ended);
    $display("Checked %0d decoded results, %0d mismatches.", scores_checked, errors);
    if (errors == 0) begin
      $display("PASS quality_block_unpacker");
    end else begin
      $display("FAIL quality_block_unpacker");
    end
    $finish;
  end

endmodule
